// ----- hw/rtl/swa_pkg.sv -----
// shared types and constants of the sliding-window arq sender
// used by every module under hw/rtl; no dependencies
package swa_pkg;

  localparam int unsigned IdxW      = 16;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned AckW      = 4;
  localparam int unsigned SendSeqW  = 4;
  localparam int unsigned StampW    = 32;

  localparam int unsigned WINDOW_DEF     = 8;
  localparam int unsigned SEQ_SPACE_DEF  = 16;
  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned AHEAD_LIMIT    = 10;

  localparam logic [CfgW-1:0] SEG_COUNT_RST = 16'd1;
  localparam logic [CfgW-1:0] TIMEOUT_RST   = 16'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ACK   = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEGMENT_COUNT = 1'd0,
    CFG_TIMEOUT_TICKS = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWAIT,
    ST_TCMP,
    ST_SLIDE,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [CfgW-1:0] segment_count;
    logic [CfgW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                fire;
    logic                send_valid;
    logic [IdxW-1:0]     send_index;
    logic [SendSeqW-1:0] send_seq;
    logic                is_resend;
    logic                done_res;
    logic                last;
  } emit_t;

endpackage

// ----- hw/rtl/sliding_window_arq_sender_core.sv -----
// top level of the sliding-window arq sender: config registers, output register
// depends on swa_pkg and swa_engine
//
// Sender side of a sliding-window ARQ transfer. Each accepted item (start, tick
// or ack) yields one or more results, the final one flagged by last_o; an item
// that commands no send yields a single status result with zero send fields.
// in_stall_o is high while an item is in work and drops once its last result
// is in the output register, so the next item can follow while that result
// waits to be taken. The shared send loop gives one result per cycle while the
// output register can take it; output stalls hold it. A start sends up to
// min(WINDOW, segment_count) segments; a tick on a live transfer first reads
// the stamp memory and compares the timeout, then resends up to WINDOW
// segments; an ack for the base first slides the window over n ring slots (at
// most AHEAD_LIMIT + 1), then sends one new segment per slot slid, so up to
// eleven sends; any other item yields a single status result. Configuration
// must be written only while the block is idle; the block does not enforce it.
module sliding_window_arq_sender_core #(
  parameter int unsigned WINDOW     = swa_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_SPACE  = swa_pkg::SEQ_SPACE_DEF,
  parameter int unsigned RING_DEPTH = swa_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [swa_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [swa_pkg::AckW-1:0]       ack_seq_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           send_valid_o,
  output logic [swa_pkg::IdxW-1:0]       send_index_o,
  output logic [swa_pkg::SendSeqW-1:0]   send_seq_o,
  output logic                           is_resend_o,
  output logic                           done_res_o,
  output logic                           last_o
);
  import swa_pkg::*;

  cfg_t  cfg_q;
  emit_t emit;
  logic  idle;
  logic  accept;
  logic  emit_ok;
  logic  out_valid_q;
  emit_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.segment_count <= SEG_COUNT_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SEGMENT_COUNT: cfg_q.segment_count <= cfg_wdata_i;
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && idle;
  assign emit_ok    = !out_valid_q || !out_stall_i;

  swa_engine #(
    .WINDOW     (WINDOW),
    .SEQ_SPACE  (SEQ_SPACE),
    .RING_DEPTH (RING_DEPTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .opcode_i  (opcode_i),
    .ack_seq_i (ack_seq_i),
    .cfg_i     (cfg_q),
    .emit_ok_i (emit_ok),
    .idle_o    (idle),
    .emit_o    (emit)
  );

  // result register, refilled when it is empty or in the cycle its held result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.fire) begin
      out_q <= emit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_valid_o = out_q.send_valid;
  assign send_index_o = out_q.send_index;
  assign send_seq_o   = out_q.send_seq;
  assign is_resend_o  = out_q.is_resend;
  assign done_res_o   = out_q.done_res;
  assign last_o       = out_q.last;

endmodule

// ----- hw/rtl/swa_stamp_ram.sv -----
// send time stamp store, one entry per ring slot, registered read
// depends on swa_pkg
module swa_stamp_ram #(
  parameter int unsigned DEPTH = swa_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [swa_pkg::StampW-1:0]       wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [swa_pkg::StampW-1:0]       rdata_o
);
  import swa_pkg::*;

  logic [StampW-1:0] mem_q [DEPTH];
  logic [StampW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/swa_engine.sv -----
// window sequencer: ack ring, window base, tick counter and send loop
// depends on swa_pkg and swa_stamp_ram
module swa_engine #(
  parameter int unsigned WINDOW     = swa_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_SPACE  = swa_pkg::SEQ_SPACE_DEF,
  parameter int unsigned RING_DEPTH = swa_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 opcode_i,
  input  logic [swa_pkg::AckW-1:0]   ack_seq_i,
  input  swa_pkg::cfg_t              cfg_i,
  input  logic                       emit_ok_i,
  output logic                       idle_o,
  output swa_pkg::emit_t             emit_o
);
  import swa_pkg::*;

  localparam int unsigned SeqW   = $clog2(SEQ_SPACE);
  localparam int unsigned RingW  = $clog2(RING_DEPTH);
  localparam int unsigned CntMax = (RING_DEPTH > WINDOW) ? RING_DEPTH : WINDOW;
  localparam int unsigned CntW   = $clog2(CntMax + 1);
  localparam int unsigned DW     = ((SeqW > RingW) ? SeqW : RingW) + 1;
  localparam int unsigned XW     = IdxW + 1;

  localparam logic [DW-1:0]     SeqLim  = DW'(SEQ_SPACE);
  localparam logic [DW-1:0]     RingLim = DW'(RING_DEPTH);
  localparam logic [DW-1:0]     AheadLim = DW'(AHEAD_LIMIT);
  localparam logic [SeqW-1:0]   SeqTop  = SeqW'(SEQ_SPACE - 1);
  localparam logic [RingW-1:0]  RingTop = RingW'(RING_DEPTH - 1);
  localparam logic [SeqW:0]     SeqLimW = (SeqW + 1)'(SEQ_SPACE);
  localparam logic [RingW:0]    RingLimW = (RingW + 1)'(RING_DEPTH);

  state_e state_q, state_d;

  logic [IdxW-1:0]       base_q, base_d;
  logic [SeqW-1:0]       base_seq_q, base_seq_d;
  logic [RingW-1:0]      base_ring_q, base_ring_d;
  logic [StampW-1:0]     now_q, now_d;
  logic                  running_q, running_d;
  logic [RING_DEPTH-1:0] acked_q, acked_d;
  logic [XW-1:0]         idx_q, idx_d;
  logic [SeqW-1:0]       seq_q, seq_d;
  logic [RingW-1:0]      ring_q, ring_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  resend_q, resend_d;

  logic [StampW-1:0] stamp_rd;
  logic [StampW-1:0] elapsed;
  logic              base_live;
  logic              ack_in_range;
  logic              ack_is_base;
  logic [DW-1:0]     ack_ext, bseq_ext, ack_dist, msum, msum_w;
  logic              mark_ok;
  logic [RingW-1:0]  mark_idx;
  logic [SeqW:0]     seq_w_sum, seq_w;
  logic [RingW:0]    ring_w_sum, ring_w;
  logic              send_empty;
  logic              send_last;
  logic              send_fire;
  logic              slide_step;
  logic              timed_out;
  logic              done_now;
  opcode_e           op;

  assign op = opcode_e'(opcode_i);

  swa_stamp_ram #(
    .DEPTH (RING_DEPTH)
  ) u_stamp (
    .clk_i   (clk_i),
    .we_i    (send_fire),
    .waddr_i (ring_q),
    .wdata_i (now_q),
    .raddr_i (base_ring_q),
    .rdata_o (stamp_rd)
  );

  // ack decode against the base sequence number
  assign base_live    = running_q && (base_q < cfg_i.segment_count);
  assign ack_ext      = DW'(ack_seq_i);
  assign bseq_ext     = DW'(base_seq_q);
  assign ack_in_range = ack_ext < SeqLim;
  assign ack_is_base  = ack_ext == bseq_ext;
  assign ack_dist     = (ack_ext >= bseq_ext) ? (ack_ext - bseq_ext)
                                              : (ack_ext + SeqLim - bseq_ext);
  assign mark_ok      = (ack_dist != '0) && (ack_dist <= AheadLim) && (ack_dist < RingLim);
  assign msum         = DW'(base_ring_q) + ack_dist;
  assign msum_w       = (msum >= RingLim) ? (msum - RingLim) : msum;
  assign mark_idx     = msum_w[RingW-1:0];

  // first index opened by an ack: base plus window, wrapped
  assign seq_w_sum  = {1'b0, base_seq_q} + (SeqW + 1)'(WINDOW);
  assign seq_w      = (seq_w_sum >= SeqLimW) ? (seq_w_sum - SeqLimW) : seq_w_sum;
  assign ring_w_sum = {1'b0, base_ring_q} + (RingW + 1)'(WINDOW);
  assign ring_w     = (ring_w_sum >= RingLimW) ? (ring_w_sum - RingLimW) : ring_w_sum;

  assign elapsed   = now_q - stamp_rd;
  assign timed_out = elapsed > StampW'(cfg_i.timeout_ticks);

  assign slide_step = base_live && acked_q[base_ring_q];
  assign send_empty = (cnt_q == '0) || (idx_q >= XW'(cfg_i.segment_count));
  assign send_last  = send_empty || (cnt_q == CntW'(1)) ||
                      ((idx_q + XW'(1)) >= XW'(cfg_i.segment_count));
  assign send_fire  = (state_q == ST_SEND) && emit_ok_i && !send_empty;
  assign done_now   = running_q && (base_q >= cfg_i.segment_count);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          state_d = ST_SEND;
          if (op == OP_TICK && base_live) begin
            state_d = ST_TWAIT;
          end else if (op == OP_ACK && base_live && ack_in_range && ack_is_base) begin
            state_d = ST_SLIDE;
          end
        end
      end
      ST_TWAIT: state_d = ST_TCMP;
      ST_TCMP:  state_d = ST_SEND;
      ST_SLIDE: begin
        if (!slide_step) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (emit_ok_i && send_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    base_d      = base_q;
    base_seq_d  = base_seq_q;
    base_ring_d = base_ring_q;
    now_d       = now_q;
    running_d   = running_q;
    acked_d     = acked_q;
    idx_d       = idx_q;
    seq_d       = seq_q;
    ring_d      = ring_q;
    cnt_d       = cnt_q;
    resend_d    = resend_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          cnt_d    = '0;
          resend_d = 1'b0;
          case (op)
            OP_START: begin
              acked_d     = '0;
              base_d      = '0;
              base_seq_d  = '0;
              base_ring_d = '0;
              running_d   = 1'b1;
              idx_d       = '0;
              seq_d       = '0;
              ring_d      = '0;
              cnt_d       = CntW'(WINDOW);
            end
            OP_TICK: begin
              now_d = now_q + StampW'(1);
            end
            OP_ACK: begin
              if (base_live && ack_in_range) begin
                if (ack_is_base) begin
                  acked_d[base_ring_q] = 1'b1;
                  idx_d  = XW'(base_q) + XW'(WINDOW);
                  seq_d  = seq_w[SeqW-1:0];
                  ring_d = ring_w[RingW-1:0];
                end else if (mark_ok) begin
                  acked_d[mark_idx] = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TCMP: begin
        if (timed_out) begin
          idx_d    = XW'(base_q);
          seq_d    = base_seq_q;
          ring_d   = base_ring_q;
          cnt_d    = CntW'(WINDOW);
          resend_d = 1'b1;
        end
      end
      ST_SLIDE: begin
        if (slide_step) begin
          acked_d[base_ring_q] = 1'b0;
          base_d      = base_q + IdxW'(1);
          base_seq_d  = (base_seq_q == SeqTop) ? '0 : base_seq_q + SeqW'(1);
          base_ring_d = (base_ring_q == RingTop) ? '0 : base_ring_q + RingW'(1);
          cnt_d       = cnt_q + CntW'(1);
        end
      end
      ST_SEND: begin
        if (send_fire) begin
          idx_d  = idx_q + XW'(1);
          seq_d  = (seq_q == SeqTop) ? '0 : seq_q + SeqW'(1);
          ring_d = (ring_q == RingTop) ? '0 : ring_q + RingW'(1);
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      base_seq_q  <= '0;
      base_ring_q <= '0;
      now_q       <= '0;
      running_q   <= 1'b0;
      acked_q     <= '0;
      cnt_q       <= '0;
      resend_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      base_seq_q  <= base_seq_d;
      base_ring_q <= base_ring_d;
      now_q       <= now_d;
      running_q   <= running_d;
      acked_q     <= acked_d;
      cnt_q       <= cnt_d;
      resend_q    <= resend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    seq_q  <= seq_d;
    ring_q <= ring_d;
  end

  assign idle_o = state_q == ST_IDLE;

  always_comb begin
    emit_o.fire       = (state_q == ST_SEND) && emit_ok_i;
    emit_o.send_valid = !send_empty;
    emit_o.send_index = send_empty ? '0 : idx_q[IdxW-1:0];
    emit_o.send_seq   = send_empty ? '0 : seq_q[SendSeqW-1:0];
    emit_o.is_resend  = !send_empty && resend_q;
    emit_o.done_res   = done_now;
    emit_o.last       = send_last;
  end

endmodule

// ----- hw/rtl/swa_checker.sv -----
// port-level checks of the sliding-window arq sender, bound to the top level
// depends on swa_pkg and sliding_window_arq_sender_core
module swa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           send_valid_o,
  input logic [swa_pkg::IdxW-1:0]       send_index_o,
  input logic [swa_pkg::SendSeqW-1:0]   send_seq_o,
  input logic                           is_resend_o,
  input logic                           done_res_o,
  input logic                           last_o
);
  import swa_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(send_index_o) &&
    $stable(send_valid_o) && $stable(last_o) && $stable(send_seq_o) &&
    $stable(is_resend_o) && $stable(done_res_o))
    else $error("stalled result changed");

  // a status result carries zero send fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> send_index_o == '0 && send_seq_o == '0 &&
    !is_resend_o)
    else $error("status result with nonzero send fields");

  // a status result is always the only and final result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> last_o)
    else $error("status result not flagged last");

endmodule

bind sliding_window_arq_sender_core swa_checker u_swa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .send_valid_o (send_valid_o),
  .send_index_o (send_index_o),
  .send_seq_o   (send_seq_o),
  .is_resend_o  (is_resend_o),
  .done_res_o   (done_res_o),
  .last_o       (last_o)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench of sliding_window_arq_sender_core: a directed table, then random transfer phases,
// every result transfer checked against the table or an in-bench model of the sender window
// depends on swa_pkg and sliding_window_arq_sender_core
module testbench;
  import swa_pkg::*;

  localparam logic [1:0]  OP_RSVD     = 2'd3;
  localparam int unsigned RingW       = $clog2(RING_DEPTH_DEF);
  localparam int unsigned RandItems   = 500;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumRows     = 27;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic                send_valid;
    logic [IdxW-1:0]     send_index;
    logic [SendSeqW-1:0] send_seq;
    logic                is_resend;
    logic                done_res;
    logic                last;
  } send_res_t;

  typedef struct packed {
    row_kind_e       kind;
    logic [1:0]      op;
    logic [AckW-1:0] ack;
    cfg_reg_e        reg_idx;
    logic [CfgW-1:0] value;
    logic            typed;
    send_res_t       res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          opcode_i;
  logic [AckW-1:0]     ack_seq_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                send_valid_o;
  logic [IdxW-1:0]     send_index_o;
  logic [SendSeqW-1:0] send_seq_o;
  logic                is_resend_o;
  logic                done_res_o;
  logic                last_o;

  // model of the sender window
  logic [CfgW-1:0]           seg_count;
  logic [CfgW-1:0]           tmo_ticks;
  logic [IdxW-1:0]           win_base;
  logic [StampW-1:0]         tick_now;
  logic [StampW-1:0]         stamp_mem [RING_DEPTH_DEF];
  logic [RING_DEPTH_DEF-1:0] acked;
  logic                      xfer_on;

  send_res_t   burst_q[$];
  send_res_t   expected_sends[$];
  stim_row_t   dir_rows [NumRows];

  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;

  sliding_window_arq_sender_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .ack_seq_i    (ack_seq_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .send_valid_o (send_valid_o),
    .send_index_o (send_index_o),
    .send_seq_o   (send_seq_o),
    .is_resend_o  (is_resend_o),
    .done_res_o   (done_res_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [RingW-1:0] ring_slot(int unsigned idx);
    return RingW'(idx % RING_DEPTH_DEF);
  endfunction

  function automatic void queue_sends(int unsigned from, int unsigned cnt, logic resend);
    int unsigned i;
    int unsigned idx;
    send_res_t   r;
    for (i = 0; i < cnt; i++) begin
      idx = from + i;
      if (idx >= 32'(seg_count)) break;
      r            = '0;
      r.send_valid = 1'b1;
      r.send_index = idx[IdxW-1:0];
      r.send_seq   = SendSeqW'(idx % SEQ_SPACE_DEF);
      r.is_resend  = resend;
      stamp_mem[ring_slot(idx)] = tick_now;
      burst_q = {burst_q, r};
    end
  endfunction

  // fills burst_q with the results of one item; returns 0 when the item changes nothing
  function automatic bit predict_sends(logic [1:0] op, logic [AckW-1:0] ack);
    int unsigned       old_base;
    int unsigned       base_seq;
    int unsigned       ack_gap;
    logic [StampW-1:0] elapsed;
    bit                effective;
    burst_q.delete();
    effective = 1'b1;
    case (op)
      OP_START: begin
        acked    = '0;
        win_base = '0;
        xfer_on  = 1'b1;
        queue_sends(0, WINDOW_DEF, 1'b0);
      end
      OP_TICK: begin
        tick_now++;
        if (xfer_on && win_base < seg_count) begin
          elapsed = tick_now - stamp_mem[ring_slot(32'(win_base))];
          if (elapsed > {16'd0, tmo_ticks}) queue_sends(32'(win_base), WINDOW_DEF, 1'b1);
        end
      end
      OP_ACK: begin
        effective = 1'b0;
        if (xfer_on && win_base < seg_count) begin
          base_seq = 32'(win_base) % SEQ_SPACE_DEF;
          if (32'(ack) == base_seq) begin
            old_base = 32'(win_base);
            acked[ring_slot(old_base)] = 1'b1;
            while (win_base < seg_count && acked[ring_slot(32'(win_base))]) begin
              acked[ring_slot(32'(win_base))] = 1'b0;
              win_base++;
            end
            queue_sends(old_base + WINDOW_DEF, 32'(win_base) - old_base, 1'b0);
            effective = 1'b1;
          end else begin
            ack_gap = (32'(ack) + SEQ_SPACE_DEF - base_seq) % SEQ_SPACE_DEF;
            if (ack_gap >= 1 && ack_gap <= AHEAD_LIMIT && ack_gap < RING_DEPTH_DEF) begin
              acked[ring_slot(32'(win_base) + ack_gap)] = 1'b1;
              effective = 1'b1;
            end
          end
        end
      end
      default: effective = 1'b0;
    endcase
    if (burst_q.size() == 0) burst_q = {burst_q, send_res_t'('0)};
    foreach (burst_q[k]) begin
      burst_q[k].done_res = xfer_on && (win_base >= seg_count);
      burst_q[k].last     = (k == burst_q.size() - 1);
    end
    return effective;
  endfunction

  function automatic string fmt_res(send_res_t r);
    return $sformatf("valid=%0b index=%0d seq=%0d resend=%0b done=%0b last=%0b",
                     r.send_valid, r.send_index, r.send_seq, r.is_resend, r.done_res, r.last);
  endfunction

  function automatic void check_result(send_res_t got);
    send_res_t want;
    results_seen++;
    if (expected_sends.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected transfer: %s", fmt_res(got));
      return;
    end
    want = expected_sends.pop_front();
    if (got.send_valid !== want.send_valid || got.send_index !== want.send_index ||
        got.send_seq !== want.send_seq || got.is_resend !== want.is_resend ||
        got.done_res !== want.done_res || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on transfer %0d: expected %s, got %s",
                 results_seen, fmt_res(want), fmt_res(got));
    end
  endfunction

  function automatic send_res_t status_res(logic done);
    send_res_t r;
    r          = '0;
    r.done_res = done;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic send_res_t one_send(logic [IdxW-1:0] idx, logic resend, logic done);
    send_res_t r;
    r            = '0;
    r.send_valid = 1'b1;
    r.send_index = idx;
    r.send_seq   = idx[SendSeqW-1:0];
    r.is_resend  = resend;
    r.done_res   = done;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row_item(logic [1:0] op, logic [AckW-1:0] ack);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_ITEM;
    r.op      = op;
    r.ack     = ack;
    r.reg_idx = CFG_SEGMENT_COUNT;
    return r;
  endfunction

  function automatic stim_row_t row_typed(logic [1:0] op, logic [AckW-1:0] ack, send_res_t res);
    stim_row_t r;
    r       = row_item(op, ack);
    r.typed = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(cfg_reg_e idx, logic [CfgW-1:0] value);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = value;
    return r;
  endfunction

  task automatic issue_item(input logic [1:0] op, input logic [AckW-1:0] ack, input bit typed,
                            input send_res_t typed_res, output bit effective);
    int unsigned gap;
    effective = predict_sends(op, ack);
    if (typed) expected_sends = {expected_sends, typed_res};
    else expected_sends = {expected_sends, burst_q};
    gap = quiet ? 32'd0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    ack_seq_i  <= ack;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle;
    in_valid_i <= 1'b0;
    while (expected_sends.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_SEGMENT_COUNT: seg_count = value;
      CFG_TIMEOUT_TICKS: tmo_ticks = value;
      default: ;
    endcase
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    send_res_t   got;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {send_valid_o, send_index_o, send_seq_o, is_resend_o, done_res_o, last_o};
        check_result(got);
        stall_left = quiet ? 32'd0 : $urandom_range(0, 8);
      end
      // long hold-off so the core fills up and stalls its input
      if (hold_req && !hold_done) begin
        stall_left = LongHold;
        hold_done  = 1'b1;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    bit              eff;
    int unsigned     rand_items;
    int unsigned     eff_items;
    int unsigned     phase_cnt;
    int unsigned     len;
    int unsigned     pick;
    logic [1:0]      op;
    logic [AckW-1:0] ack;
    logic [CfgW-1:0] seg_val;
    logic [CfgW-1:0] tmo_val;
    rand_items   = 0;
    eff_items    = 0;
    phase_cnt    = 0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    seg_count    = SEG_COUNT_RST;
    tmo_ticks    = TIMEOUT_RST;
    win_base     = '0;
    tick_now     = '0;
    acked        = '0;
    xfer_on      = 1'b0;
    foreach (stamp_mem[i]) stamp_mem[i] = '0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_SEGMENT_COUNT;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_START;
    ack_seq_i   <= '0;

    dir_rows = '{
      row_typed(OP_TICK,  4'd0,  status_res(1'b0)),
      row_typed(OP_ACK,   4'd0,  status_res(1'b0)),
      row_typed(OP_RSVD,  4'd15, status_res(1'b0)),
      row_typed(OP_START, 4'd0,  one_send(16'd0, 1'b0, 1'b0)),
      row_typed(OP_TICK,  4'd0,  status_res(1'b0)),
      row_typed(OP_TICK,  4'd0,  status_res(1'b0)),
      row_typed(OP_TICK,  4'd0,  one_send(16'd0, 1'b1, 1'b0)),
      row_typed(OP_ACK,   4'd0,  status_res(1'b1)),
      row_typed(OP_TICK,  4'd0,  status_res(1'b1)),
      row_typed(OP_ACK,   4'd5,  status_res(1'b1)),
      row_cfg(CFG_SEGMENT_COUNT, 16'hFFFF),
      row_cfg(CFG_TIMEOUT_TICKS, 16'h0000),
      row_item(OP_START, 4'd0),
      row_item(OP_TICK,  4'd0),
      row_typed(OP_ACK,  4'd11, status_res(1'b0)),
      row_typed(OP_ACK,  4'd15, status_res(1'b0)),
      row_item(OP_ACK, 4'd1),
      row_item(OP_ACK, 4'd2),
      row_item(OP_ACK, 4'd3),
      row_item(OP_ACK, 4'd4),
      row_item(OP_ACK, 4'd5),
      row_item(OP_ACK, 4'd6),
      row_item(OP_ACK, 4'd7),
      row_item(OP_ACK, 4'd8),
      row_item(OP_ACK, 4'd9),
      row_item(OP_ACK, 4'd10),
      row_item(OP_ACK, 4'd0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[n].reg_idx, dir_rows[n].value);
      end else begin
        issue_item(dir_rows[n].op, dir_rows[n].ack, dir_rows[n].typed, dir_rows[n].res, eff);
        if (eff) eff_items++;
      end
    end

    while (rand_items < RandItems) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       seg_val = 16'd1;
        1:       seg_val = 16'hFFFF;
        2:       seg_val = CfgW'($urandom_range(9, 24));
        default: seg_val = CfgW'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       tmo_val = 16'd0;
        1:       tmo_val = 16'hFFFF;
        default: tmo_val = CfgW'($urandom_range(1, 8));
      endcase
      write_reg(CFG_SEGMENT_COUNT, seg_val);
      write_reg(CFG_TIMEOUT_TICKS, tmo_val);
      quiet = ($urandom_range(0, 3) == 0);
      if (phase_cnt == 2) hold_req = 1'b1;
      issue_item(OP_START, AckW'($urandom_range(0, 15)), 1'b0, '0, eff);
      rand_items++;
      if (eff) eff_items++;
      len = $urandom_range(20, 50);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        ack  = AckW'($urandom_range(0, 15));
        if (pick < 3) begin
          op = OP_START;
        end else if (pick < 5) begin
          op = OP_RSVD;
        end else if (pick < 25) begin
          op = OP_TICK;
        end else begin
          op = OP_ACK;
          // mostly acks for the base or a slot a little ahead of it
          if (pick >= 35)
            ack = AckW'(32'(win_base) + (pick[0] ? 32'd0 : $urandom_range(1, AHEAD_LIMIT)));
        end
        issue_item(op, ack, 1'b0, '0, eff);
        rand_items++;
        if (eff) eff_items++;
      end
      phase_cnt++;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d directed rows and %0d items over %0d random phases with long hold-off",
             NumRows, items_sent, phase_cnt);
    $display("%0d items moved the window state; checked %0d result transfers, %0d mismatches",
             eff_items, results_seen, mismatches);
    if (mismatches == 0 && expected_sends.size() == 0) begin
      $display("sliding_window_arq_sender_core verification clean");
    end else begin
      $display("sliding_window_arq_sender_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results still expected", expected_sends.size());
    $display("sliding_window_arq_sender_core verification failed");
    $finish;
  end

endmodule
